// File: rtl/frc_pkg.sv
// shared types, tables and constants for the frame rate control word packer
package frc_pkg;

	localparam int PAGE_COUNT  = 5;
	localparam int LEVEL_COUNT = 16;
	localparam int PIXELS      = 8;
	localparam int LEVEL_W     = 4;
	localparam int OVL_PIX_W   = 3;
	localparam int PAGE_W      = 3;
	localparam int WORD_W      = 16;
	localparam int GRAY_W      = PIXELS * LEVEL_W;
	localparam int OVL_W       = PIXELS * OVL_PIX_W;

	localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

	// overlay pixel: bit 2 is the transparent mask, bits 1..0 the colour
	localparam int COLOR_MASK_BIT = 2;

	// apb register map
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_OVERLAY_ENABLE = 1'b0;

	// plane pair codes: bit 1 is the second plane (high byte), bit 0 the first
	localparam logic [1:0] PLANE_NONE = 2'b00;
	localparam logic [1:0] PLANE_HI   = 2'b10;
	localparam logic [1:0] PLANE_LO   = 2'b01;
	localparam logic [1:0] PLANE_BOTH = 2'b11;

	localparam logic [1:0] GRAY_MAP [PAGE_COUNT][LEVEL_COUNT] = '{
		'{PLANE_NONE, PLANE_HI,   PLANE_NONE, PLANE_HI,   PLANE_HI,   PLANE_HI,
		  PLANE_LO,   PLANE_HI,   PLANE_LO,   PLANE_LO,   PLANE_LO,   PLANE_BOTH,
		  PLANE_LO,   PLANE_BOTH, PLANE_BOTH, PLANE_BOTH},
		'{PLANE_NONE, PLANE_NONE, PLANE_HI,   PLANE_NONE, PLANE_HI,   PLANE_HI,
		  PLANE_HI,   PLANE_LO,   PLANE_HI,   PLANE_LO,   PLANE_LO,   PLANE_LO,
		  PLANE_BOTH, PLANE_LO,   PLANE_BOTH, PLANE_BOTH},
		'{PLANE_NONE, PLANE_NONE, PLANE_NONE, PLANE_HI,   PLANE_HI,   PLANE_HI,
		  PLANE_HI,   PLANE_HI,   PLANE_LO,   PLANE_LO,   PLANE_LO,   PLANE_LO,
		  PLANE_LO,   PLANE_BOTH, PLANE_BOTH, PLANE_BOTH},
		'{PLANE_NONE, PLANE_NONE, PLANE_HI,   PLANE_NONE, PLANE_HI,   PLANE_HI,
		  PLANE_HI,   PLANE_LO,   PLANE_HI,   PLANE_LO,   PLANE_LO,   PLANE_LO,
		  PLANE_BOTH, PLANE_LO,   PLANE_BOTH, PLANE_BOTH},
		'{PLANE_NONE, PLANE_NONE, PLANE_NONE, PLANE_HI,   PLANE_NONE, PLANE_HI,
		  PLANE_HI,   PLANE_HI,   PLANE_LO,   PLANE_HI,   PLANE_LO,   PLANE_LO,
		  PLANE_LO,   PLANE_BOTH, PLANE_LO,   PLANE_BOTH}
	};

	localparam logic [1:0] OVL_MAP [4] = '{PLANE_NONE, PLANE_HI, PLANE_LO, PLANE_BOTH};

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic valid_s3;
	} pipe_ctrl_t;

endpackage

// File: rtl/frc_gray_lcd_word_packer.sv
// top level of the frame rate control gray lcd word packer
//
// pixel channel: pixel_valid / pixel_stall with gray_pixels, overlay_pixels
// and page; a request is taken at a clock edge with pixel_valid high and
// pixel_stall low. word channel: word_valid / word_stall with lcd_word.
// each request gives exactly one lcd word, in order.
// throughput is one request per cycle while pixel_stall is low; the path from
// the accepting edge to word_valid runs through the input register, the table
// lookup stage and the overlay merge stage.
// pages above four use the last table row.
// overlay_enable is written through the apb port at byte address 0 and is
// sampled with each request as it enters; write it only while idle.
// reset clears the stage valid bits and overlay_enable; pixel_stall is low
// as reset is released, so a request can be taken right away.
// when word_stall is held, the output word holds and the stages behind it
// fill; pixel_stall rises only once all three stages are full.
module frc_gray_lcd_word_packer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  logic [frc_pkg::GRAY_W-1:0]   gray_pixels,
	input  logic [frc_pkg::OVL_W-1:0]    overlay_pixels,
	input  logic [frc_pkg::PAGE_W-1:0]   page,
	output logic                         word_valid,
	input  logic                         word_stall,
	output logic [frc_pkg::WORD_W-1:0]   lcd_word,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [frc_pkg::PADDR_W-1:0]  paddr,
	input  logic [frc_pkg::PDATA_W-1:0]  pwdata,
	output logic [frc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	frc_pkg::pipe_ctrl_t          ctrl;
	logic                         ovl_en_q;
	logic [frc_pkg::GRAY_W-1:0]   gray_s1;
	logic [frc_pkg::OVL_W-1:0]    ovl_s1;
	logic [frc_pkg::PAGE_W-1:0]   page_s1;
	logic                         ovl_en_s1;
	logic [frc_pkg::WORD_W-1:0]   gray_word_s2;
	logic                         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[frc_pkg::PADDR_W-1] == frc_pkg::REG_OVERLAY_ENABLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_en_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			ovl_en_q <= pwdata[0];
		end
	end

	assign prdata = reg_sel ? {{(frc_pkg::PDATA_W-1){1'b0}}, ovl_en_q} : '0;

	frc_pipe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.word_stall  (word_stall),
		.pixel_stall (pixel_stall),
		.ctrl        (ctrl)
	);

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			gray_s1   <= gray_pixels;
			ovl_s1    <= overlay_pixels;
			page_s1   <= (page > frc_pkg::PAGE_LAST) ? frc_pkg::PAGE_LAST : page;
			ovl_en_s1 <= ovl_en_q;
		end
	end

	frc_gray_map u_gray (
		.clk          (clk),
		.en           (ctrl.en_s2),
		.gray_s1      (gray_s1),
		.page_s1      (page_s1),
		.gray_word_s2 (gray_word_s2)
	);

	frc_ovl_merge u_merge (
		.clk          (clk),
		.ctrl         (ctrl),
		.ovl_s1       (ovl_s1),
		.ovl_en_s1    (ovl_en_s1),
		.gray_word_s2 (gray_word_s2),
		.lcd_word_s3  (lcd_word)
	);

	assign word_valid = ctrl.valid_s3;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> u_ctrl.valid_s1)
		else $error("accepted request did not enter stage one");

	a_empty_out_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!word_valid |-> !pixel_stall)
		else $error("input stalled with an empty output stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (word_valid && word_stall && u_ctrl.valid_s1 && u_ctrl.valid_s2))
		else $error("input stalled while the pipeline had room");

endmodule

// File: rtl/frc_pipe_ctrl.sv
// valid tracking and stall chain for the three stage pipeline
module frc_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	input  logic                word_stall,
	output logic                pixel_stall,
	output frc_pkg::pipe_ctrl_t ctrl
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;

	// a stage moves when it is empty or the one after it moves
	assign ready_s3 = !valid_s3 || !word_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pixel_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign pixel_stall   = !ready_s1;
	assign ctrl.en_s1    = ready_s1;
	assign ctrl.en_s2    = ready_s2;
	assign ctrl.en_s3    = ready_s3;
	assign ctrl.valid_s3 = valid_s3;

endmodule

// File: rtl/frc_gray_map.sv
// gray level to plane bit lookup for eight pixels, registered into stage two
module frc_gray_map (
	input  logic                        clk,
	input  logic                        en,
	input  logic [frc_pkg::GRAY_W-1:0]  gray_s1,
	input  logic [frc_pkg::PAGE_W-1:0]  page_s1,
	output logic [frc_pkg::WORD_W-1:0]  gray_word_s2
);

	logic [frc_pkg::WORD_W-1:0] word;

	always_comb begin
		logic [1:0] code;
		word = '0;
		for (int i = 0; i < frc_pkg::PIXELS; i++) begin
			code = frc_pkg::GRAY_MAP[page_s1][gray_s1[i*frc_pkg::LEVEL_W +: frc_pkg::LEVEL_W]];
			word[i]                  = code[0];
			word[i + frc_pkg::PIXELS] = code[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_word_s2 <= word;
		end
	end

endmodule

// File: rtl/frc_ovl_merge.sv
// overlay keep and colour planes in stage two, merge with gray word in stage three
module frc_ovl_merge (
	input  logic                        clk,
	input  frc_pkg::pipe_ctrl_t         ctrl,
	input  logic [frc_pkg::OVL_W-1:0]   ovl_s1,
	input  logic                        ovl_en_s1,
	input  logic [frc_pkg::WORD_W-1:0]  gray_word_s2,
	output logic [frc_pkg::WORD_W-1:0]  lcd_word_s3
);

	logic [frc_pkg::WORD_W-1:0] keep;
	logic [frc_pkg::WORD_W-1:0] color;
	logic [frc_pkg::WORD_W-1:0] keep_s2;
	logic [frc_pkg::WORD_W-1:0] color_s2;

	always_comb begin
		logic [frc_pkg::OVL_PIX_W-1:0] px;
		logic [1:0]                    code;
		logic                          hold;
		keep  = '0;
		color = '0;
		for (int i = 0; i < frc_pkg::PIXELS; i++) begin
			px   = ovl_s1[i*frc_pkg::OVL_PIX_W +: frc_pkg::OVL_PIX_W];
			// transparent pixels and a disabled overlay keep the gray result
			hold = px[frc_pkg::COLOR_MASK_BIT] || !ovl_en_s1;
			code = hold ? frc_pkg::PLANE_NONE : frc_pkg::OVL_MAP[px[1:0]];
			keep[i]                    = hold;
			keep[i + frc_pkg::PIXELS]  = hold;
			color[i]                   = code[0];
			color[i + frc_pkg::PIXELS] = code[1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			keep_s2  <= keep;
			color_s2 <= color;
		end
		if (ctrl.en_s3) begin
			lcd_word_s3 <= (gray_word_s2 & keep_s2) | (color_s2 & ~keep_s2);
		end
	end

endmodule

// File: dv/tb.sv
// self-checking testbench for the frame rate control gray lcd word packer
`timescale 1ns / 1ps

module tb;

	localparam int PAGE_COUNT     = frc_pkg::PAGE_COUNT;
	localparam int LEVEL_COUNT    = frc_pkg::LEVEL_COUNT;
	localparam int PIXELS         = frc_pkg::PIXELS;
	localparam int LEVEL_W        = frc_pkg::LEVEL_W;
	localparam int OVL_PIX_W      = frc_pkg::OVL_PIX_W;
	localparam int PAGE_W         = frc_pkg::PAGE_W;
	localparam int WORD_W         = frc_pkg::WORD_W;
	localparam int GRAY_W         = frc_pkg::GRAY_W;
	localparam int OVL_W          = frc_pkg::OVL_W;
	localparam int COLOR_MASK_BIT = frc_pkg::COLOR_MASK_BIT;
	localparam int PADDR_W        = frc_pkg::PADDR_W;
	localparam int PDATA_W        = frc_pkg::PDATA_W;
	localparam logic [PAGE_W-1:0] PAGE_LAST = frc_pkg::PAGE_LAST;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PRESSURE_AT    = 300;
	localparam int PRESSURE_HOLD  = 100;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_ITEMS    = 225;
	localparam int PIPE_DEPTH     = 3;

	localparam logic [PADDR_W-1:0] OVERLAY_ADDR = PADDR_W'(4 * frc_pkg::REG_OVERLAY_ENABLE);
	localparam logic [OVL_W-1:0]   ALL_MASKED   = 24'h924924;

	// plane bit codes: first plane in bit 0, second plane in bit 8
	localparam bit [WORD_W-1:0] P0 = 16'h000;
	localparam bit [WORD_W-1:0] PH = 16'h100;
	localparam bit [WORD_W-1:0] PL = 16'h001;
	localparam bit [WORD_W-1:0] PB = 16'h101;

	localparam bit [WORD_W-1:0] LEVEL_PLANES [PAGE_COUNT][LEVEL_COUNT] = '{
		'{P0, PH, P0, PH, PH, PH, PL, PH, PL, PL, PL, PB, PL, PB, PB, PB},
		'{P0, P0, PH, P0, PH, PH, PH, PL, PH, PL, PL, PL, PB, PL, PB, PB},
		'{P0, P0, P0, PH, PH, PH, PH, PH, PL, PL, PL, PL, PL, PB, PB, PB},
		'{P0, P0, PH, P0, PH, PH, PH, PL, PH, PL, PL, PL, PB, PL, PB, PB},
		'{P0, P0, P0, PH, P0, PH, PH, PH, PL, PH, PL, PL, PL, PB, PL, PB}
	};
	localparam bit [WORD_W-1:0] COLOUR_PLANES [4] = '{P0, PH, PL, PB};

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic [OVL_W-1:0]  ovl;
		logic [PAGE_W-1:0] pg;
		logic              ovl_en;
		logic              typed;
		logic [WORD_W-1:0] word;
	} pixel_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam pixel_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{32'h00000000, 24'h000000, 3'd0, 1'b0, 1'b1, 16'h0000},
		'{32'hFFFFFFFF, 24'h000000, 3'd0, 1'b0, 1'b1, 16'hFFFF},
		'{32'hEEEEEEEE, 24'h000000, 3'd7, 1'b0, 1'b1, 16'h00FF},
		'{32'h44444444, 24'h000000, 3'd5, 1'b0, 1'b1, 16'h0000},
		'{32'h76543210, 24'h000000, 3'd0, 1'b0, 1'b0, 16'h0000},
		'{32'h76543210, 24'h000000, 3'd1, 1'b0, 1'b0, 16'h0000},
		'{32'h76543210, 24'h000000, 3'd2, 1'b0, 1'b0, 16'h0000},
		'{32'h76543210, 24'h000000, 3'd3, 1'b0, 1'b0, 16'h0000},
		'{32'h76543210, 24'h000000, 3'd4, 1'b0, 1'b0, 16'h0000},
		'{32'hFEDCBA98, 24'h000000, 3'd4, 1'b0, 1'b0, 16'h0000},
		'{32'hFEDCBA98, 24'h000000, 3'd1, 1'b0, 1'b0, 16'h0000},
		// overlay off: overlay pixels have no effect
		'{32'h00000000, 24'hFFFFFF, 3'd0, 1'b0, 1'b1, 16'h0000},
		'{32'h89ABCDEF, 24'h3AC5A3, 3'd6, 1'b0, 1'b0, 16'h0000},
		'{32'hFFFFFFFF, 24'h000000, 3'd0, 1'b1, 1'b1, 16'h0000},
		'{32'h00000000, {8{3'b011}}, 3'd3, 1'b1, 1'b1, 16'hFFFF},
		'{32'hFFFFFFFF, {8{3'b100}}, 3'd0, 1'b1, 1'b1, 16'hFFFF},
		// transparent pixels with colour bits set still keep the gray result
		'{32'h00000000, {8{3'b111}}, 3'd2, 1'b1, 1'b1, 16'h0000},
		'{32'h00000000, {8{3'b001}}, 3'd1, 1'b1, 1'b1, 16'hFF00},
		'{32'h00000000, {8{3'b010}}, 3'd4, 1'b1, 1'b1, 16'h00FF},
		'{32'hFFFFFFFF, {3'b111, 3'b110, 3'b101, 3'b100, 3'b011, 3'b010, 3'b001, 3'b000},
			3'd2, 1'b1, 1'b0, 16'h0000},
		'{32'h76543210, {3'b000, 3'b001, 3'b010, 3'b011, 3'b100, 3'b101, 3'b110, 3'b111},
			3'd7, 1'b1, 1'b0, 16'h0000},
		'{32'hFFFFFFFF, 24'hFFFFFF, 3'd0, 1'b1, 1'b1, 16'hFFFF},
		'{32'h12345678, 24'hA5C3E1, 3'd3, 1'b1, 1'b0, 16'h0000}
	};

	logic                clk;
	logic                arst_n;
	logic                pixel_valid;
	logic                pixel_stall;
	logic [GRAY_W-1:0]   gray_pixels;
	logic [OVL_W-1:0]    overlay_pixels;
	logic [PAGE_W-1:0]   page;
	logic                word_valid;
	logic                word_stall;
	logic [WORD_W-1:0]   lcd_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	logic [WORD_W-1:0] words_due [$];
	logic              overlay_on;
	int                errors;
	int                quiet_cycles = 0;
	int                send_calm;

	frc_gray_lcd_word_packer DUT (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.gray_pixels(gray_pixels), .overlay_pixels(overlay_pixels), .page(page),
		.word_valid(word_valid), .word_stall(word_stall), .lcd_word(lcd_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] packed_word(input logic [GRAY_W-1:0] gray,
			input logic [OVL_W-1:0] ovl, input logic [PAGE_W-1:0] pg, input logic ovl_en);
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] keep;
		logic [WORD_W-1:0] colour;
		int                row;
		logic [2:0]        px;
		word   = '0;
		keep   = '0;
		colour = '0;
		row    = (pg > PAGE_LAST) ? int'(PAGE_LAST) : int'(pg);
		for (int i = 0; i < PIXELS; i++)
			word |= LEVEL_PLANES[row][gray[LEVEL_W*i +: LEVEL_W]] << i;
		if (ovl_en) begin
			for (int i = 0; i < PIXELS; i++) begin
				px = ovl[OVL_PIX_W*i +: OVL_PIX_W];
				if (px[COLOR_MASK_BIT])
					keep |= PB << i;
				else
					colour |= COLOUR_PLANES[px[1:0]] << i;
			end
			word = (word & keep) | (colour & ~keep);
		end
		return word;
	endfunction

	task automatic send_pixels(input logic [GRAY_W-1:0] gray, input logic [OVL_W-1:0] ovl,
			input logic [PAGE_W-1:0] pg, input logic typed, input logic [WORD_W-1:0] word);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = $urandom_range(0, 12);
			if ($urandom_range(0, 15) == 0)
				send_calm = $urandom_range(20, 40);
		end
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid    <= 1'b1;
		gray_pixels    <= gray;
		overlay_pixels <= ovl;
		page           <= pg;
		do @(posedge clk); while (pixel_stall);
		words_due.push_back(typed ? word : packed_word(gray, ovl, pg, overlay_on));
	endtask

	task automatic set_overlay(input logic en);
		pixel_valid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= OVERLAY_ADDR;
		pwdata  <= PDATA_W'(en);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// read it back straight after the write
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(en)) begin
			$display("%0t: overlay_enable read back expected %h got %h", $time,
				PDATA_W'(en), prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		overlay_on = en;
	endtask

	// word side: random stalls, calm stretches and one long hold-off
	initial begin
		int gap;
		int taken;
		int calm;
		taken = 0;
		calm  = 0;
		word_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken == PRESSURE_AT) begin
				gap = PRESSURE_HOLD;
			end else if (calm > 0) begin
				gap = 0;
				calm--;
			end else begin
				gap = $urandom_range(0, 12);
				if ($urandom_range(0, 15) == 0)
					calm = $urandom_range(20, 40);
			end
			if (gap > 0) begin
				word_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				word_stall <= 1'b0;
			end
			do @(posedge clk); while (!word_valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_valid && !word_stall) begin
			if (words_due.size() == 0) begin
				$display("%0t: lcd_word expected none got %h", $time, lcd_word);
				errors++;
			end else if (lcd_word !== words_due[0]) begin
				$display("%0t: lcd_word expected %h got %h", $time, words_due[0], lcd_word);
				errors++;
				void'(words_due.pop_front());
			end else begin
				void'(words_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (word_valid && !word_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [GRAY_W-1:0] gray;
		logic [OVL_W-1:0]  ovl;
		logic [PAGE_W-1:0] pg;
		errors         = 0;
		send_calm      = 0;
		overlay_on     = 1'b0;
		arst_n         <= 1'b0;
		pixel_valid    <= 1'b0;
		gray_pixels    <= '0;
		overlay_pixels <= '0;
		page           <= '0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].ovl_en != overlay_on)
				set_overlay(DIRECTED[i].ovl_en);
			send_pixels(DIRECTED[i].gray, DIRECTED[i].ovl, DIRECTED[i].pg,
				DIRECTED[i].typed, DIRECTED[i].word);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_overlay(ph % 2 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0)
					gray = {PIXELS{4'($urandom_range(0, 15))}};
				else
					gray = $urandom;
				case ($urandom_range(0, 3))
					0: ovl = OVL_W'($urandom);
					1: ovl = OVL_W'($urandom) | ALL_MASKED;
					2: ovl = OVL_W'($urandom) & ~ALL_MASKED;
					default: ovl = '0;
				endcase
				// mostly legal pages, some that saturate
				pg = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				send_pixels(gray, ovl, pg, 1'b0, '0);
			end
		end

		pixel_valid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 5) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: frc_gray_lcd_word_packer.f
rtl/frc_pkg.sv
rtl/frc_pipe_ctrl.sv
rtl/frc_gray_map.sv
rtl/frc_ovl_merge.sv
rtl/frc_gray_lcd_word_packer.sv
dv/tb.sv
